### src/rmt_pkg.sv
// Shared types and constants for the running median tracker.
`default_nettype none
package rmt_pkg;

	localparam int SAMPLE_W     = 32;
	localparam int MED_W        = 33;
	localparam int CAPACITY_DEF = 1024;

	// Operation applied to a whole chain of cells
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REPLACE
	} op_t;

	// Command broadcast to every cell of one chain
	typedef struct packed {
		op_t                        op;
		logic signed [SAMPLE_W-1:0] x;
	} chain_cmd_t;

endpackage
`default_nettype wire

### src/running_median_tracker_unit.sv
// Top level of the running median tracker: balance control and two cell chains.
//
// Usage:
//   A sample transaction is taken at a rising edge with start high and busy
//   low. busy stays low: the cell chains insert, shift or swap their heads
//   in parallel in all cells, so a new sample may be offered every clock.
//   One result follows each sample. done is high for exactly one cycle, the
//   cycle after the sample was taken (throughput 1 per cycle), with
//   median_times_two, stored_count and refused on the result ports. The
//   receiver must take it in that cycle; it cannot stall the block.
//   The lower half is a chain with its maximum at the head, the upper half a
//   chain with its minimum at the head; every cell compares its value with the
//   broadcast value and shifts from a neighbor, so each head is always ready.
//   When CAPACITY samples are held, further samples are refused and the
//   median and count stay as they were.
//   Reset (arst_n low) empties both halves by clearing the counts; cell
//   contents need no clearing since only cells below the count are used.
`default_nettype none
module running_median_tracker_unit #(
	parameter int CAPACITY = rmt_pkg::CAPACITY_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire  signed [rmt_pkg::SAMPLE_W-1:0]  sample,
	output logic                                 done,
	output logic signed [rmt_pkg::MED_W-1:0]     median_times_two,
	output logic [$clog2(CAPACITY+1)-1:0]        stored_count,
	output logic                                 refused
);
	import rmt_pkg::*;

	localparam int LOWER_DEPTH = (CAPACITY + 1) / 2;
	localparam int UPPER_DEPTH = CAPACITY / 2;
	localparam int CNT_W       = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]           lc_q;
	logic [CNT_W-1:0]           uc_q;
	logic [CNT_W-1:0]           lc_d;
	logic [CNT_W-1:0]           uc_d;
	logic [CNT_W-1:0]           total;
	logic                       full;
	logic                       accept;
	logic                       done_q;
	logic                       refused_q;
	logic signed [SAMPLE_W-1:0] lo_head;
	logic signed [SAMPLE_W-1:0] up_head;
	chain_cmd_t                 lo_cmd;
	chain_cmd_t                 up_cmd;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign total  = lc_q + uc_q;
	assign full   = (total == CNT_W'(CAPACITY));

	// Decide where the sample goes and what crosses between the halves
	always_comb begin
		lc_d      = lc_q;
		uc_d      = uc_q;
		lo_cmd.op = OP_HOLD;
		lo_cmd.x  = sample;
		up_cmd.op = OP_HOLD;
		up_cmd.x  = sample;
		if (accept && !full) begin
			if ((lc_q == '0) || (sample <= lo_head)) begin
				if (lc_q == uc_q + CNT_W'(1)) begin
					// lower maximum crosses up, sample takes its place
					up_cmd.op = OP_INSERT;
					up_cmd.x  = lo_head;
					lo_cmd.op = OP_REPLACE;
					uc_d      = uc_q + CNT_W'(1);
				end else begin
					lo_cmd.op = OP_INSERT;
					lc_d      = lc_q + CNT_W'(1);
				end
			end else if (uc_q == lc_q) begin
				if ((uc_q == '0) || (sample <= up_head)) begin
					lo_cmd.op = OP_INSERT;
					lc_d      = lc_q + CNT_W'(1);
				end else begin
					// upper minimum crosses down, sample takes its place
					lo_cmd.op = OP_INSERT;
					lo_cmd.x  = up_head;
					up_cmd.op = OP_REPLACE;
					lc_d      = lc_q + CNT_W'(1);
				end
			end else begin
				up_cmd.op = OP_INSERT;
				uc_d      = uc_q + CNT_W'(1);
			end
		end
	end

	rmt_chain #(
		.DEPTH   (LOWER_DEPTH),
		.DESCEND (1'b1),
		.CNT_W   (CNT_W)
	) u_lower (
		.clk   (clk),
		.cmd   (lo_cmd),
		.count (lc_q),
		.head  (lo_head)
	);

	rmt_chain #(
		.DEPTH   (UPPER_DEPTH),
		.DESCEND (1'b0),
		.CNT_W   (CNT_W)
	) u_upper (
		.clk   (clk),
		.cmd   (up_cmd),
		.count (uc_q),
		.head  (up_head)
	);

	// Advance counts and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q      <= '0;
			uc_q      <= '0;
			done_q    <= 1'b0;
			refused_q <= 1'b0;
		end else begin
			lc_q      <= lc_d;
			uc_q      <= uc_d;
			done_q    <= accept;
			refused_q <= accept && full;
		end
	end

	// Form the result from the updated heads and counts
	always_comb begin
		done         = done_q;
		refused      = refused_q;
		stored_count = total;
		if (total[0] || (uc_q == '0)) begin
			median_times_two = {lo_head[SAMPLE_W-1], lo_head} + {lo_head[SAMPLE_W-1], lo_head};
		end else begin
			median_times_two = {lo_head[SAMPLE_W-1], lo_head} + {up_head[SAMPLE_W-1], up_head};
		end
	end

endmodule
`default_nettype wire

### src/rmt_cell.sv
// One cell of a sorted chain: holds one value and shifts with its neighbors.
`default_nettype none
module rmt_cell #(
	parameter int INDEX   = 0,
	parameter bit DESCEND = 1'b0,
	parameter int CNT_W   = 11
) (
	input  wire                                 clk,
	input  rmt_pkg::chain_cmd_t                 cmd,
	input  wire  [CNT_W-1:0]                    count,
	input  wire  signed [rmt_pkg::SAMPLE_W-1:0] prev_val,
	input  wire                                 prev_keep,
	input  wire  signed [rmt_pkg::SAMPLE_W-1:0] next_val,
	input  wire                                 next_keep,
	output logic signed [rmt_pkg::SAMPLE_W-1:0] val,
	output logic                                keep
);
	import rmt_pkg::*;

	localparam bit IS_FIRST = (INDEX == 0);

	logic                       occ;
	logic signed [SAMPLE_W-1:0] val_d;
	logic signed [SAMPLE_W-1:0] val_q;

	assign val = val_q;

	// Flag a held value that ranks at or ahead of the broadcast value
	always_comb begin
		occ  = (count > CNT_W'(INDEX));
		keep = occ && (DESCEND ? (val_q >= cmd.x) : (val_q <= cmd.x));
	end

	// Pick the new value from self, the broadcast value or a neighbor
	always_comb begin
		val_d = val_q;
		unique case (cmd.op)
			OP_HOLD: begin
				val_d = val_q;
			end
			OP_INSERT: begin
				if (keep) begin
					val_d = val_q;
				end else if (IS_FIRST || prev_keep) begin
					val_d = cmd.x;
				end else begin
					val_d = prev_val;
				end
			end
			OP_REPLACE: begin
				if (next_keep) begin
					val_d = next_val;
				end else if (IS_FIRST || keep) begin
					val_d = cmd.x;
				end else begin
					val_d = val_q;
				end
			end
			default: begin
				val_d = val_q;
			end
		endcase
	end

	// Store the value
	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule
`default_nettype wire

### src/rmt_chain.sv
// Row of sorted cells forming one half of the sample store.
`default_nettype none
module rmt_chain #(
	parameter int DEPTH   = 512,
	parameter bit DESCEND = 1'b0,
	parameter int CNT_W   = 11
) (
	input  wire                                 clk,
	input  rmt_pkg::chain_cmd_t                 cmd,
	input  wire  [CNT_W-1:0]                    count,
	output logic signed [rmt_pkg::SAMPLE_W-1:0] head
);
	import rmt_pkg::*;

	logic signed [SAMPLE_W-1:0] val_a  [DEPTH];
	logic                       keep_a [DEPTH];
	logic signed [SAMPLE_W-1:0] pv_a   [DEPTH];
	logic                       pk_a   [DEPTH];
	logic signed [SAMPLE_W-1:0] nv_a   [DEPTH];
	logic                       nk_a   [DEPTH];

	assign head = val_a[0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		// Wire the neighbor toward the head
		if (i == 0) begin : g_first
			assign pv_a[i] = val_a[i];
			assign pk_a[i] = 1'b0;
		end else begin : g_mid_prev
			assign pv_a[i] = val_a[i-1];
			assign pk_a[i] = keep_a[i-1];
		end

		// Wire the neighbor toward the tail
		if (i == DEPTH - 1) begin : g_last
			assign nv_a[i] = val_a[i];
			assign nk_a[i] = 1'b0;
		end else begin : g_mid_next
			assign nv_a[i] = val_a[i+1];
			assign nk_a[i] = keep_a[i+1];
		end

		rmt_cell #(
			.INDEX   (i),
			.DESCEND (DESCEND),
			.CNT_W   (CNT_W)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.count     (count),
			.prev_val  (pv_a[i]),
			.prev_keep (pk_a[i]),
			.next_val  (nv_a[i]),
			.next_keep (nk_a[i]),
			.val       (val_a[i]),
			.keep      (keep_a[i])
		);
	end

endmodule
`default_nettype wire

### src/rmt_checker.sv
// Port-level checks for the running median tracker, bound to the top level.
`default_nettype none
module rmt_checker #(
	parameter int CAPACITY = rmt_pkg::CAPACITY_DEF
) (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 start,
	input wire                                 busy,
	input wire signed [rmt_pkg::SAMPLE_W-1:0]  sample,
	input wire                                 done,
	input wire signed [rmt_pkg::MED_W-1:0]     median_times_two,
	input wire [$clog2(CAPACITY+1)-1:0]        stored_count,
	input wire                                 refused
);
	import rmt_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// One result strobe for each taken transaction, in the cycle after it
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (done == $past(start && !busy && arst_n)))
		else $error("result strobe does not match taken transaction");

	// Refuse only at a full store
	a_refuse_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && refused) |-> (stored_count == CNT_W'(CAPACITY)))
		else $error("sample refused below capacity");

	// A kept sample raises the count by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !refused) |-> (stored_count == $past(stored_count) + CNT_W'(1)))
		else $error("count did not advance by one");

	// A refused sample leaves median and count alone
	a_refuse_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && refused) |-> ($stable(median_times_two) && $stable(stored_count)))
		else $error("refused sample changed the held answer");

endmodule

bind running_median_tracker_unit rmt_checker #(.CAPACITY(CAPACITY)) u_rmt_checker (.*);
`default_nettype wire
